[rtl/bee_pkg.sv]
// shared types, constants and register codes for the band energy event detector
package bee_pkg;

   // field widths
   localparam int BIN_W    = 8;
   localparam int POWER_W  = 32;
   localparam int ENERGY_W = 38;
   localparam int LIMIT_W  = 32;
   localparam int CSR_W    = 38;

   // block geometry
   localparam int NUM_BINS        = 256;
   localparam int COOLDOWN_BLOCKS = 7;

   localparam logic [BIN_W-1:0] BAND_LO   = BIN_W'(64);
   localparam logic [BIN_W-1:0] BAND_HI   = BIN_W'(128);
   localparam logic [BIN_W-1:0] LIMIT_BIN = BIN_W'(1);

   // raised threshold is (1 + 2 * cooldown) times the base
   localparam int RAISE_FACTOR = 2 * COOLDOWN_BLOCKS + 1;
   localparam int CD_W         = $clog2(COOLDOWN_BLOCKS + 1);
   localparam int THR_W        = ENERGY_W + $clog2(RAISE_FACTOR + 1);

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

   // register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_THRESHOLD  = 2'd0,
      CSR_LOW_BIN_LIMIT = 2'd1,
      CSR_LIMIT_ENABLE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BIN_W-1:0]   bin_index;
      logic [POWER_W-1:0] bin_power;
      logic               block_end;
      logic               detector_active;
   } bee_req_type;

   typedef struct packed {
      logic                turn_on;
      logic                turn_off;
      logic [ENERGY_W-1:0] band_energy;
   } bee_rsp_type;

   // block totals handed from the accumulator to the decision logic
   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic                limit_hit;
   } bee_band_type;

endpackage

[rtl/bee_accum.sv]
// band energy accumulator and low bin limit flag
module bee_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  bee_pkg::bee_req_type        item,
   input  logic [bee_pkg::LIMIT_W-1:0] low_bin_limit,
   output bee_pkg::bee_band_type       band
);
   import bee_pkg::*;

   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic                hit_ff, hit_in;
   logic [ENERGY_W-1:0] energy_next;
   logic                hit_next;
   logic [ENERGY_W:0]   sum;
   logic                in_range;
   logic                in_band;

   assign in_range = (32'(item.bin_index) < 32'(NUM_BINS));
   assign in_band  = in_range && (item.bin_index >= BAND_LO) && (item.bin_index < BAND_HI);
   assign sum      = {1'b0, energy_ff} + (ENERGY_W + 1)'(item.bin_power);

   always_comb begin
      energy_next = energy_ff;
      if (in_band) begin
         energy_next = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
      end
      hit_next = hit_ff;
      if (in_range && (item.bin_index == LIMIT_BIN)) begin
         hit_next = (item.bin_power > low_bin_limit);
      end
   end

   assign band.energy    = energy_next;
   assign band.limit_hit = hit_next;

   // totals restart after the block end
   always_comb begin
      energy_in = energy_ff;
      hit_in    = hit_ff;
      if (step) begin
         energy_in = item.block_end ? '0 : energy_next;
         hit_in    = item.block_end ? 1'b0 : hit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         energy_ff <= energy_in;
         hit_ff    <= hit_in;
      end
   end

endmodule

[rtl/bee_decide.sv]
// threshold cooldown, warm-up and trigger decision at each block end
module bee_decide (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         block_end,
   input  logic                         detector_active,
   input  bee_pkg::bee_band_type        band,
   input  logic [bee_pkg::ENERGY_W-1:0] on_threshold,
   input  logic                         limit_enable,
   input  logic                         thr_load,
   input  logic [bee_pkg::ENERGY_W-1:0] thr_load_value,
   output logic                         turn_on,
   output logic                         turn_off
);
   import bee_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [CD_W-1:0]  cool_ff, cool_in;
   logic             warm_ff, warm_in;
   logic [THR_W-1:0] thr_next;
   logic [CD_W-1:0]  cool_next;
   logic             warm_next;
   logic             warm_mid;
   logic             sat;
   logic [THR_W-1:0] base_ext;

   assign base_ext = THR_W'(on_threshold);

   always_comb begin
      thr_next  = thr_ff;
      cool_next = cool_ff;
      warm_mid  = warm_ff;
      if (limit_enable) begin
         if (band.limit_hit) begin
            cool_next = CD_W'(COOLDOWN_BLOCKS);
            thr_next  = base_ext * THR_W'(RAISE_FACTOR);
            warm_mid  = 1'b0;
         end else if (cool_ff != '0) begin
            cool_next = cool_ff - CD_W'(1);
            thr_next  = thr_ff - (base_ext << 1);
         end
      end

      sat       = (THR_W'(band.energy) > thr_next);
      turn_on   = 1'b0;
      warm_next = warm_mid;
      if (!detector_active) begin
         if (!limit_enable) begin
            turn_on = sat;
         end else if (warm_mid) begin
            warm_next = 1'b0;
            turn_on   = sat;
         end else if (sat) begin
            warm_next = 1'b1;
         end
      end
      turn_off = (band.energy < on_threshold);
   end

   // base threshold write reloads the active threshold
   always_comb begin
      thr_in  = thr_ff;
      cool_in = cool_ff;
      warm_in = warm_ff;
      if (thr_load) begin
         thr_in  = THR_W'(thr_load_value);
         cool_in = '0;
      end else if (step && block_end) begin
         thr_in  = thr_next;
         cool_in = cool_next;
         warm_in = warm_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         cool_ff <= '0;
         warm_ff <= 1'b0;
      end else begin
         thr_ff  <= thr_in;
         cool_ff <= cool_in;
         warm_ff <= warm_in;
      end
   end

endmodule

[rtl/band_energy_event_detector.sv]
// top level of the band energy event detector: handshake, registers, datapath
//
//   channel | ports                          | direction
//   --------+--------------------------------+-----------
//   req     | req_valid req_ready req_data   | in, one bin per transfer
//   rsp     | rsp_valid rsp_ready rsp_data   | out, one result per block end
//   csr     | csr_we csr_index csr_wdata     | in, write only
//
// one bin per cycle sustained unless rsp stalls; a bin is held in the input
// register and its block result is then loaded into the output register
// the input register advances whenever the bin produces no result or the
// output register is free, so a stalled rsp side only holds block end bins
// synchronous reset clears the control state, the totals and the registers
// (on_threshold 0, low_bin_limit all ones, limit_enable 0)
module band_energy_event_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bee_pkg::bee_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bee_pkg::bee_rsp_type          rsp_data,
   input  logic                          csr_we,
   input  logic [bee_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bee_pkg::CSR_W-1:0]     csr_wdata
);
   import bee_pkg::*;

   // input stage
   bee_req_type         in_ff, in_in;
   logic                in_valid_ff, in_valid_in;
   // output stage
   bee_rsp_type         out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   // configuration registers
   logic [ENERGY_W-1:0] on_thr_ff, on_thr_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic                limit_en_ff, limit_en_in;

   logic                out_free;
   logic                step;
   logic                req_take;
   logic                thr_load;
   bee_band_type        band;
   logic                turn_on;
   logic                turn_off;

   // bins without a result never wait on the rsp side
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!in_ff.block_end || out_free);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   assign thr_load = csr_we && (csr_index == CSR_ON_THRESHOLD);

   always_comb begin
      on_thr_in   = on_thr_ff;
      limit_in    = limit_ff;
      limit_en_in = limit_en_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ON_THRESHOLD:  on_thr_in   = csr_wdata[ENERGY_W-1:0];
            CSR_LOW_BIN_LIMIT: limit_in    = csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_ENABLE:  limit_en_in = csr_wdata[0];
            default: begin
               // unused index, write is dropped
            end
         endcase
      end
   end

   bee_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_ff),
      .low_bin_limit (limit_ff),
      .band          (band)
   );

   bee_decide u_decide (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .block_end       (in_ff.block_end),
      .detector_active (in_ff.detector_active),
      .band            (band),
      .on_threshold    (on_thr_ff),
      .limit_enable    (limit_en_ff),
      .thr_load        (thr_load),
      .thr_load_value  (csr_wdata[ENERGY_W-1:0]),
      .turn_on         (turn_on),
      .turn_off        (turn_off)
   );

   // input register loads on every req transfer
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_in       = req_data;
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // output register loads a result when a block end bin advances
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (step && in_ff.block_end) begin
         out_in.turn_on     = turn_on;
         out_in.turn_off    = turn_off;
         out_in.band_energy = band.energy;
         out_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         on_thr_ff    <= '0;
         limit_ff     <= {LIMIT_W{1'b1}};
         limit_en_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         on_thr_ff    <= on_thr_in;
         limit_ff     <= limit_in;
         limit_en_ff  <= limit_en_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
